>>> hw/rtl/one_way_elevator_disk_scheduler_defines.svh
// Assertion macros for the one-way elevator disk scheduler.
// Included by the top level; expects signals clk and arst_n in scope.
`ifndef ONE_WAY_ELEVATOR_DISK_SCHEDULER_DEFINES_SVH
`define ONE_WAY_ELEVATOR_DISK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OWDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define OWDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/owds_pkg.sv
// Shared constants and types for the one-way elevator disk scheduler.
// No dependencies; used by the interfaces, the store cell and the top level.
package owds_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TRACK_BITS  = 16;
	localparam int ID_BITS     = 8;
	localparam int AGE_BITS    = 16;
	localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Best entry seen so far by the search that ripples along the cell row.
	typedef struct packed {
		logic                  found;
		logic [IDX_BITS-1:0]   idx;
		logic [TRACK_BITS-1:0] track;
		logic [ID_BITS-1:0]    requester;
		logic [AGE_BITS-1:0]   waited;
	} pick_t;

	// One candidate among upper entries only, one among all entries (wrap case).
	typedef struct packed {
		pick_t up;
		pick_t any;
	} cand_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic                  wr;
		logic                  wr_upper;
		logic [TRACK_BITS-1:0] wr_track;
		logic [ID_BITS-1:0]    wr_requester;
		logic [AGE_BITS-1:0]   arrival;
		logic                  clr;
		logic [IDX_BITS-1:0]   clr_idx;
		logic                  wrap;
	} ctl_t;

endpackage

>>> hw/rtl/owds_if.sv
// Valid/ready channel interfaces for the disk scheduler's item and result sides.
// Depends on owds_pkg for the field widths.
interface owds_item_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [owds_pkg::TRACK_BITS-1:0] track;
	logic [owds_pkg::ID_BITS-1:0]    requester;

	modport source(output valid, opcode, track, requester, input ready);
	modport sink(input valid, opcode, track, requester, output ready);
endinterface

interface owds_result_if;
	logic                            valid;
	logic                            ready;
	logic                            grant_valid;
	logic [owds_pkg::ID_BITS-1:0]    grant_requester;
	logic [owds_pkg::TRACK_BITS-1:0] grant_track;
	logic                            rejected;
	logic                            disk_busy;

	modport source(output valid, grant_valid, grant_requester, grant_track, rejected,
		disk_busy, input ready);
	modport sink(input valid, grant_valid, grant_requester, grant_track, rejected,
		disk_busy, output ready);
endinterface

>>> hw/rtl/owds_cell.sv
// One slot of the waiting store plus one stage of the least-track search.
// Depends on owds_pkg for the candidate and control structs.
module owds_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [owds_pkg::IDX_BITS-1:0] cell_idx,
	input  owds_pkg::ctl_t                ctl,
	input  logic                          free_in,
	output logic                          free_out,
	input  owds_pkg::cand_t               cand_in,
	output owds_pkg::cand_t               cand_out,
	output logic                          occupied
);

	logic                            valid_q;
	logic                            upper_q;
	logic [owds_pkg::TRACK_BITS-1:0] track_q;
	logic [owds_pkg::ID_BITS-1:0]    requester_q;
	logic [owds_pkg::AGE_BITS-1:0]   age_q;
	owds_pkg::cand_t                 cand_q;

	logic [owds_pkg::AGE_BITS-1:0]   waited;
	owds_pkg::pick_t                 mine;
	owds_pkg::cand_t                 cand_d;
	logic                            take;

	// Lower track wins; on equal tracks the one that has waited longer wins.
	function automatic logic beats(owds_pkg::pick_t a, owds_pkg::pick_t b);
		beats = !b.found || (a.track < b.track) ||
			((a.track == b.track) && (a.waited > b.waited));
	endfunction

	assign waited   = ctl.arrival - age_q;
	assign take     = ctl.wr && !free_in && !valid_q;
	assign free_out = free_in || !valid_q;
	assign occupied = valid_q;
	assign cand_out = cand_q;

	always_comb begin
		mine.found     = 1'b1;
		mine.idx       = cell_idx;
		mine.track     = track_q;
		mine.requester = requester_q;
		mine.waited    = waited;
		cand_d         = cand_in;
		if (valid_q && upper_q && beats(mine, cand_in.up)) begin
			cand_d.up = mine;
		end
		if (valid_q && beats(mine, cand_in.any)) begin
			cand_d.any = mine;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= '0;
		end else begin
			cand_q <= cand_d;
			if (take) begin
				valid_q <= 1'b1;
			end else if (ctl.clr && (ctl.clr_idx == cell_idx)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			upper_q     <= ctl.wr_upper;
			track_q     <= ctl.wr_track;
			requester_q <= ctl.wr_requester;
			age_q       <= ctl.arrival;
		end else if (ctl.wrap && valid_q) begin
			upper_q <= 1'b1;
		end
	end

endmodule

>>> hw/rtl/one_way_elevator_disk_scheduler.sv
// One-way elevator (C-SCAN) disk arbiter.
// Item channel (sink): opcode, track, requester. Request (opcode 0) asks for
// the disk; release (opcode 1) hands it on. Result channel (source): exactly one
// result per item with grant_valid, grant_requester, grant_track, rejected and
// disk_busy. A request is finished in the cycle it is taken and its result goes
// straight into the result register. A release on a busy disk searches the row
// of QUEUE_DEPTH store cells: the best candidate moves one cell per clock, and
// the result is loaded once the search counter has stepped over the row. A
// release on an idle disk returns at once. Items are taken one at a time; a new
// item is taken in the same cycle that the previous result is transferred, or at
// any time while the result register is empty and no search is running. When
// the receiver stalls, the result is held and no item is taken.
// Reset (arst_n low) empties the store, idles the disk and clears the current
// track and the arrival counter; no clearing pass is needed.
// Depends on owds_pkg, owds_if.sv, owds_cell and the defines header.
`include "one_way_elevator_disk_scheduler_defines.svh"

module one_way_elevator_disk_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	owds_item_if.sink     item,
	owds_result_if.source result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t                          state_q;
	logic                            busy_q;
	logic [owds_pkg::TRACK_BITS-1:0] cur_track_q;
	logic [owds_pkg::AGE_BITS-1:0]   arrival_q;
	logic [owds_pkg::IDX_BITS-1:0]   scan_cnt_q;

	logic                            out_valid_q;
	logic                            out_grant_q;
	logic [owds_pkg::ID_BITS-1:0]    out_requester_q;
	logic [owds_pkg::TRACK_BITS-1:0] out_track_q;
	logic                            out_rejected_q;
	logic                            out_busy_q;

	owds_pkg::cand_t                 chain [owds_pkg::QUEUE_DEPTH+1];
	logic                            free_chain [owds_pkg::QUEUE_DEPTH+1];
	logic [owds_pkg::QUEUE_DEPTH-1:0] occupied;

	owds_pkg::ctl_t                  ctl;
	owds_pkg::pick_t                 pick;
	logic                            accept;
	logic                            is_req;
	logic                            full;
	logic                            scan_done;
	logic                            out_load;

	assign chain[0]      = '0;
	assign free_chain[0] = 1'b0;

	for (genvar i = 0; i < owds_pkg::QUEUE_DEPTH; i++) begin : g_cell
		owds_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (owds_pkg::IDX_BITS'(i)),
			.ctl      (ctl),
			.free_in  (free_chain[i]),
			.free_out (free_chain[i+1]),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.occupied (occupied[i])
		);
	end

	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign accept     = item.valid && item.ready;
	assign is_req     = (item.opcode == owds_pkg::OP_REQUEST);
	assign full       = !free_chain[owds_pkg::QUEUE_DEPTH];
	assign scan_done  = (state_q == ST_SCAN) &&
		(scan_cnt_q == owds_pkg::IDX_BITS'(owds_pkg::QUEUE_DEPTH - 1));

	// Every item but a release on a busy disk has its result ready at once.
	assign out_load = (accept && (is_req || !busy_q)) || scan_done;

	// With no upper entry left the sweep wraps and the best of all entries wins.
	assign pick = chain[owds_pkg::QUEUE_DEPTH].up.found ?
		chain[owds_pkg::QUEUE_DEPTH].up : chain[owds_pkg::QUEUE_DEPTH].any;

	always_comb begin
		ctl.wr           = accept && is_req && busy_q && !full;
		ctl.wr_upper     = (item.track >= cur_track_q);
		ctl.wr_track     = item.track;
		ctl.wr_requester = item.requester;
		ctl.arrival      = arrival_q;
		ctl.clr          = scan_done && pick.found;
		ctl.clr_idx      = pick.idx;
		ctl.wrap         = scan_done && !chain[owds_pkg::QUEUE_DEPTH].up.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			cur_track_q <= '0;
			arrival_q   <= '0;
			scan_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_req && !busy_q) begin
							busy_q      <= 1'b1;
							cur_track_q <= item.track;
						end else if (is_req) begin
							if (!full) begin
								arrival_q <= arrival_q + 1'b1;
							end
						end else if (busy_q) begin
							state_q    <= ST_SCAN;
							scan_cnt_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
						if (pick.found) begin
							cur_track_q <= pick.track;
						end else begin
							busy_q <= 1'b0;
						end
					end else begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload; it only matters while out_valid_q is set.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_grant_q     <= is_req && !busy_q;
			out_requester_q <= (is_req && !busy_q) ? item.requester : '0;
			out_track_q     <= (is_req && !busy_q) ? item.track : '0;
			out_rejected_q  <= is_req && busy_q && full;
			out_busy_q      <= is_req || busy_q;
		end else if (scan_done) begin
			out_grant_q     <= pick.found;
			out_requester_q <= pick.found ? pick.requester : '0;
			out_track_q     <= pick.found ? pick.track : '0;
			out_rejected_q  <= 1'b0;
			out_busy_q      <= pick.found;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.grant_valid     = out_grant_q;
	assign result.grant_requester = out_requester_q;
	assign result.grant_track     = out_track_q;
	assign result.rejected        = out_rejected_q;
	assign result.disk_busy       = out_busy_q;

	// An idle disk never has requests waiting.
	`OWDS_ASSERT_NOW(a_idle_store_empty, !busy_q, occupied == '0, "store not empty while idle")
	// A delivered grant always leaves the disk held and is never a rejection.
	`OWDS_ASSERT_NOW(a_grant_consistent, out_valid_q && out_grant_q,
		out_busy_q && !out_rejected_q, "grant result inconsistent")
	// A release on a busy disk always starts the cell search.
	`OWDS_ASSERT_NEXT(a_release_scans, accept && !is_req && busy_q,
		state_q == ST_SCAN, "release did not start the search")

endmodule
